[src/lkc_pkg.sv]
package lkc_pkg;

  // Build-time sizes
  localparam int NUM_POSITIONS  = 8;
  localparam int KEY_READ_BYTES = 4;

  // Request codes
  localparam logic [2:0] ACT_TICK       = 3'd0;
  localparam logic [2:0] ACT_POWER_ON   = 3'd1;
  localparam logic [2:0] ACT_BRIGHTNESS = 3'd2;
  localparam logic [2:0] ACT_DIGIT      = 3'd3;
  localparam logic [2:0] ACT_LED        = 3'd4;
  localparam logic [2:0] ACT_READ_KEYS  = 3'd5;

  // Frame bytes
  localparam logic [7:0] CMD_POWER_ON   = 8'h8F;
  localparam logic [7:0] CMD_BRIGHTNESS = 8'h88;
  localparam logic [7:0] CMD_WRITE      = 8'h44;
  localparam logic [7:0] ADDR_BASE      = 8'hC0;
  localparam logic [7:0] CMD_READ_KEYS  = 8'h42;
  localparam logic [7:0] BRIGHT_MAX     = 8'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] position;
    logic [7:0] value;
    logic       dio_in;
  } req_t;

  typedef struct packed {
    logic       strobe_res;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       key_valid;
    logic [3:0] key_code;
    logic [7:0] key_bits;
  } rsp_t;

  // Hex seven-segment patterns, segment a in bit 0
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

[src/lkc_seq.sv]
module lkc_seq
  import lkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  req_t       req,
  input  logic [7:0] ticks_per_phase,
  output rsp_t       res
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CMD   = 3'd1,
    ST_GAP   = 3'd2,
    ST_ADDR  = 3'd3,
    ST_DATA  = 3'd4,
    ST_KCMD  = 3'd5,
    ST_KREAD = 3'd6
  } step_t;

  localparam logic [6:0] BYTE_BITS = 7'd8;
  localparam logic [6:0] READ_BITS = 7'(8 * KEY_READ_BYTES);

  step_t      step, step_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] pending_address, pending_address_next;
  logic [7:0] pending_data, pending_data_next;
  logic [5:0] bit_count, bit_count_next;
  logic [7:0] phase_ticks, phase_ticks_next;
  logic       clock_high, clock_high_next;
  logic [7:0] key_accumulator, key_accumulator_next;

  logic [7:0] tpp;
  logic [8:0] tick_sum;
  logic [6:0] bit_sum;
  logic [3:0] key_pos;
  logic [7:0] bright;
  logic       pos_ok;

  // Highest set bit plus one, zero when empty
  function automatic logic [3:0] code_of(input logic [7:0] bits);
    logic [3:0] code;
    code = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (bits[k]) code = 4'(k + 1);
    end
    return code;
  endfunction

  assign tpp    = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
  assign bright = (req.value > BRIGHT_MAX) ? BRIGHT_MAX : req.value;
  assign pos_ok = {1'b0, req.position} < 4'(NUM_POSITIONS);

  always_comb begin
    step_next            = step;
    shift_byte_next      = shift_byte;
    pending_address_next = pending_address;
    pending_data_next    = pending_data;
    bit_count_next       = bit_count;
    phase_ticks_next     = phase_ticks;
    clock_high_next      = clock_high;
    key_accumulator_next = key_accumulator;
    tick_sum             = '0;
    bit_sum              = '0;
    key_pos              = '0;
    res                  = '0;

    // Start a request when idle
    if (step == ST_IDLE) begin
      unique case (req.action) inside
        ACT_POWER_ON: begin
          pending_address_next = '0;
          step_next            = ST_CMD;
          shift_byte_next      = CMD_POWER_ON;
        end
        ACT_BRIGHTNESS: begin
          pending_address_next = '0;
          step_next            = ST_CMD;
          shift_byte_next      = CMD_BRIGHTNESS | bright;
        end
        ACT_DIGIT, ACT_LED: begin
          if (pos_ok) begin
            if (req.action == ACT_DIGIT) begin
              pending_address_next = ADDR_BASE | {4'b0, req.position, 1'b0};
              pending_data_next    = seg_of(req.value[3:0]);
            end else begin
              pending_address_next = ADDR_BASE | {4'b0, req.position, 1'b1};
              pending_data_next    = {7'b0, req.value != 8'd0};
            end
            step_next       = ST_CMD;
            shift_byte_next = CMD_WRITE;
          end
        end
        ACT_READ_KEYS: begin
          key_accumulator_next = '0;
          step_next            = ST_KCMD;
          shift_byte_next      = CMD_READ_KEYS;
        end
        default: begin
        end
      endcase
      if (step_next != ST_IDLE) begin
        bit_count_next   = '0;
        phase_ticks_next = '0;
        clock_high_next  = 1'b0;
      end
    end

    // Pin levels for this tick
    res.busy_res = (step_next != ST_IDLE);
    if (step_next == ST_IDLE || step_next == ST_GAP) begin
      res.strobe_res   = 1'b1;
      res.serial_clock = 1'b0;
      res.data_out     = 1'b0;
      res.data_drive   = 1'b1;
    end else if (step_next == ST_KREAD) begin
      res.strobe_res   = 1'b0;
      res.serial_clock = clock_high_next;
      res.data_out     = 1'b0;
      res.data_drive   = 1'b0;
    end else begin
      res.strobe_res   = 1'b0;
      res.serial_clock = clock_high_next;
      res.data_out     = shift_byte_next[0];
      res.data_drive   = 1'b1;
    end

    // Advance the bit timing
    if (step_next == ST_GAP) begin
      step_next        = ST_ADDR;
      shift_byte_next  = pending_address_next;
      bit_count_next   = '0;
      phase_ticks_next = '0;
      clock_high_next  = 1'b0;
    end else if (step_next != ST_IDLE) begin
      tick_sum = {1'b0, phase_ticks_next} + 9'd1;
      phase_ticks_next = tick_sum[7:0];
      if (tick_sum >= {1'b0, tpp}) begin
        phase_ticks_next = '0;
        if (!clock_high_next) begin
          // Sample the data pin at the end of the low phase
          key_pos = {1'b0, bit_count_next[5:3]} + {1'b0, bit_count_next[2:0]};
          if (step_next == ST_KREAD && req.dio_in && !key_pos[3]) begin
            key_accumulator_next[key_pos[2:0]] = 1'b1;
          end
          clock_high_next = 1'b1;
        end else begin
          clock_high_next = 1'b0;
          bit_sum         = {1'b0, bit_count_next} + 7'd1;
          bit_count_next  = bit_sum[5:0];
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_sum >= ((step_next == ST_KREAD) ? READ_BITS : BYTE_BITS)) begin
            unique case (step_next)
              ST_CMD: begin
                step_next      = (pending_address_next != 8'd0) ? ST_GAP : ST_IDLE;
                bit_count_next = '0;
              end
              ST_ADDR: begin
                step_next        = ST_DATA;
                shift_byte_next  = pending_data_next;
                bit_count_next   = '0;
                phase_ticks_next = '0;
                clock_high_next  = 1'b0;
              end
              ST_KCMD: begin
                step_next        = ST_KREAD;
                shift_byte_next  = '0;
                bit_count_next   = '0;
                phase_ticks_next = '0;
                clock_high_next  = 1'b0;
              end
              ST_KREAD: begin
                res.key_valid  = 1'b1;
                res.key_code   = code_of(key_accumulator_next);
                res.key_bits   = key_accumulator_next;
                step_next      = ST_IDLE;
                bit_count_next = '0;
              end
              default: begin
                step_next      = ST_IDLE;
                bit_count_next = '0;
              end
            endcase
          end
        end
      end
    end
  end

  // Hold sequencer state between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= ST_IDLE;
      shift_byte      <= '0;
      pending_address <= '0;
      pending_data    <= '0;
      bit_count       <= '0;
      phase_ticks     <= '0;
      clock_high      <= 1'b0;
      key_accumulator <= '0;
    end else if (advance) begin
      step            <= step_next;
      shift_byte      <= shift_byte_next;
      pending_address <= pending_address_next;
      pending_data    <= pending_data_next;
      bit_count       <= bit_count_next;
      phase_ticks     <= phase_ticks_next;
      clock_high      <= clock_high_next;
      key_accumulator <= key_accumulator_next;
    end
  end

  a_key_done_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && res.key_valid) |=> (step == ST_IDLE))
    else $error("key read finished but sequencer not idle");

  a_gap_to_addr: assert property (@(posedge clk) disable iff (rst)
    (advance && step == ST_GAP) |=> (step == ST_ADDR && shift_byte == pending_address))
    else $error("gap tick not followed by address frame");

  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    (step == ST_KREAD) |-> (shift_byte == 8'd0))
    else $error("shift byte not empty while reading keys");

endmodule

[src/led_keypad_serial_controller.sv]
// Channel  | Signals                       | Transfer when
// ---------+-------------------------------+-----------------------------
// request  | req_valid, req_stall, req     | req_valid && !req_stall
// result   | rsp_valid, rsp_stall, rsp     | rsp_valid && !rsp_stall
// config   | cfg_valid, cfg_ready, cfg_data| cfg_valid && cfg_ready
//
// One request is one tick of the pin sequencer; its result is registered and
// appears the cycle after the transfer, so one tick is taken every cycle unless
// stalled. The single result register sets the rate: req_stall rises only while
// a held result is stalled. Synchronous reset idles the sequencer, empties the
// result register and sets ticks_per_phase to 1. Config writes are always ready.
module led_keypad_serial_controller
  import lkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] ticks_per_phase;
  logic       advance;
  rsp_t       res;

  assign cfg_ready = 1'b1;
  assign req_stall = rsp_valid && rsp_stall;
  assign advance   = req_valid && !req_stall;

  // Hold the phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_phase <= cfg_data;
    end
  end

  lkc_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .req             (req),
    .ticks_per_phase (ticks_per_phase),
    .res             (res)
  );

  // Result register: load on each request transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= res;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("request transfer produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !advance)
    else $error("request taken while result is stalled");

endmodule
